@@ hdl/ssmif_pkg.sv @@
// ----------------------------------------------------------------------------
// ssmif_pkg
// Shared sizes, command codes and beat types of the slot store.
// ----------------------------------------------------------------------------
package ssmif_pkg;

    // Table geometry
    localparam int SLOT_COUNT = 256;
    localparam int VALUE_BITS = 32;

    // Fixed field widths of the command and result beats
    localparam int INDEX_FIELD_BITS = 8;
    localparam int VALUE_FIELD_BITS = 32;

    // Only slots that an 8-bit index can reach are ever written, so the
    // memory holds no more than those
    localparam int INDEX_REACH = 1 << INDEX_FIELD_BITS;
    localparam int MEM_DEPTH   = (SLOT_COUNT < INDEX_REACH) ? SLOT_COUNT : INDEX_REACH;
    localparam int ADDR_BITS   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Stored and compared value width: bits above VALUE_BITS are dropped
    localparam int KEY_BITS = (VALUE_BITS < VALUE_FIELD_BITS) ? VALUE_BITS : VALUE_FIELD_BITS;

    // Command codes
    localparam logic CMD_CHANGE = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    typedef struct packed {
        logic                        command;
        logic [INDEX_FIELD_BITS-1:0] slot_index;
        logic [VALUE_FIELD_BITS-1:0] value;
    } request_t;

    typedef struct packed {
        logic                        found;
        logic [INDEX_FIELD_BITS-1:0] lowest_slot;
    } response_t;

endpackage

@@ hdl/ssmif_slot_ram.sv @@
// ----------------------------------------------------------------------------
// ssmif_slot_ram
// Single-port synchronous RAM: one write or one read per cycle, read data
// registered.
// ----------------------------------------------------------------------------
module ssmif_slot_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/slot_store_min_index_find.sv @@
// ----------------------------------------------------------------------------
// slot_store_min_index_find
// Slot table with change and lowest-matching-slot find commands.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. A change writes
// its slot in the cycle it is taken and leaves busy low, so changes go at one
// per cycle. A find of zero answers on the next cycle. Any other find scans
// the single-port slot memory from slot 0 upward, one read per cycle through
// the registered read port, and holds busy high until it hits or has checked
// the last slot. The result shows in the first cycle that busy is low again.
// The result is shown for exactly one cycle with done high and cannot be held
// off, so it must be taken then. After reset the block clears the memory one
// slot per cycle with busy high.
// ----------------------------------------------------------------------------
module slot_store_min_index_find
    import ssmif_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  request_t  request,
    output logic      busy,
    output logic      done,
    output response_t response
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;

    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(MEM_DEPTH - 1);

    logic [1:0]           state_reg, state_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic                 pend_reg, pend_next;
    logic [ADDR_BITS-1:0] pend_idx_reg, pend_idx_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic                 done_reg, done_next;
    response_t            response_reg, response_next;

    logic                 accept;
    logic [KEY_BITS-1:0]  in_key;
    logic                 in_range;
    logic                 ram_we;
    logic                 ram_re;
    logic [ADDR_BITS-1:0] ram_addr;
    logic [KEY_BITS-1:0]  ram_wdata;
    logic [KEY_BITS-1:0]  ram_rdata;

    assign accept   = start && (state_reg == ST_IDLE);
    assign in_key   = request.value[KEY_BITS-1:0];
    assign in_range = 32'(request.slot_index) < 32'(SLOT_COUNT);

    // Drive the memory port: clear sweep, change write or scan read
    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = addr_reg;
        ram_wdata = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                ram_addr  = request.slot_index[ADDR_BITS-1:0];
                ram_wdata = in_key;
                ram_we    = accept && (request.command == CMD_CHANGE) && in_range;
            end
            ST_SCAN:
            begin
                ram_re = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    ssmif_slot_ram #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (KEY_BITS),
        .AW    (ADDR_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Sequence clear, idle and scan; compare each returned slot to the key
    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        key_next      = key_reg;
        done_next     = 1'b0;
        response_next = response_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (request.command == CMD_FIND))
                begin
                    if (in_key == '0)
                    begin
                        // empty marker never matches
                        done_next     = 1'b1;
                        response_next = '0;
                    end
                    else
                    begin
                        key_next   = in_key;
                        addr_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // issue the next read, wrapping reads past the end are dropped
                addr_next     = addr_reg + 1'b1;
                pend_next     = 1'b1;
                pend_idx_next = addr_reg;
                if (pend_reg)
                begin
                    priority if (ram_rdata == key_reg)
                    begin
                        done_next                 = 1'b1;
                        response_next.found       = 1'b1;
                        response_next.lowest_slot = INDEX_FIELD_BITS'(pend_idx_reg);
                        pend_next                 = 1'b0;
                        addr_next                 = '0;
                        state_next                = ST_IDLE;
                    end
                    else if (pend_idx_reg == LAST_ADDR)
                    begin
                        done_next     = 1'b1;
                        response_next = '0;
                        pend_next     = 1'b0;
                        addr_next     = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        // no hit yet: keep scanning
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        key_reg      <= key_next;
        response_reg <= response_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign response = response_reg;

endmodule

@@ hdl/ssmif_checker.sv @@
// ----------------------------------------------------------------------------
// ssmif_checker
// Port-level checks of the slot store, bound to the top level.
// ----------------------------------------------------------------------------
module ssmif_checker
    import ssmif_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input request_t  request,
    input logic      busy,
    input logic      done,
    input response_t response
);

    // A miss reports slot zero
    a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !response.found |-> response.lowest_slot == '0)
        else $error("miss beat with nonzero slot");

    // A change beat never causes a result
    a_change_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (request.command == CMD_CHANGE) |=> !done)
        else $error("result after change beat");

    // A result follows a scan or a find beat taken on the edge before
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || ($past(start) && ($past(request.command) == CMD_FIND)))
        else $error("result with no find behind it");

    // A find of zero answers not found on the next cycle
    a_find_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (request.command == CMD_FIND) &&
        (request.value[KEY_BITS-1:0] == '0) |=> done && !response.found)
        else $error("find of zero not answered as miss");

    // Leaving reset starts the clearing sweep
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> busy)
        else $error("not busy while clearing after reset");

endmodule

bind slot_store_min_index_find ssmif_checker u_checker (.*);
